// ----- sv/crs_pkg.sv -----
// Shared constants and codes for the Catmull-Rom spline evaluator.
`default_nettype none
package crs_pkg;

  // Default table depth and fraction bits
  localparam int MAX_NODES_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  // Fixed field widths
  localparam int WORD_W  = 32;
  localparam int ENTRY_W = 6;
  localparam int NCFG_W  = 7;

  // Request codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage
`default_nettype wire

// ----- sv/catmull_rom_spline_eval.sv -----
// Catmull-Rom spline evaluator: node/value tables, sequencer, shared mul and div units.
//
//   Channel   Signals                                         Direction
//   --------  ----------------------------------------------  ---------
//   in        in_valid, in_stall, cmd, entry_index,           in
//             node_word, value_word, query_x
//   out       out_valid, out_stall, result_value, in_range    out
//   cfg       cfg_we, cfg_wdata (num_nodes)                   in
//
// Load request: written to both tables on acceptance, no result. Query request:
// range check, then straight to the result outside the node range; else a binary
// search, per tangent a bit-serial multiply and a 64-step restoring divide, a
// divide for t, multiplies for t^2 and t^3, and one multiply per Hermite term.
// in_stall is high for the whole query, until its result is taken.
// Synchronous reset returns the sequencer to idle and num_nodes to 2.
`default_nettype none
module catmull_rom_spline_eval
  import crs_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      cmd,
  input  wire logic [ENTRY_W-1:0]        entry_index,
  input  wire logic signed [WORD_W-1:0]  node_word,
  input  wire logic signed [WORD_W-1:0]  value_word,
  input  wire logic signed [WORD_W-1:0]  query_x,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [WORD_W-1:0]       result_value,
  output logic                           in_range,
  input  wire logic                      cfg_we,
  input  wire logic [NCFG_W-1:0]         cfg_wdata
);

  localparam int F       = FRAC_BITS;
  localparam int IDX_W   = $clog2(MAX_NODES);
  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int TW      = F + 1;
  localparam int HW      = F + 4;
  localparam int MA_W    = 37;
  localparam int MB_W    = (HW > 32) ? HW : 32;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = PROD_W + 3;
  localparam int DIVD_W  = 64;
  localparam int DCNT_W  = $clog2(DIVD_W + 1);
  localparam int DW      = 38;

  localparam logic [TW-1:0] ONE_T = TW'(1) << F;
  localparam logic signed [ACC_W-1:0] RES_MAX = $signed({{(ACC_W-32){1'b0}}, 32'h7fffffff});
  localparam logic signed [ACC_W-1:0] RES_MIN = $signed({{(ACC_W-32){1'b1}}, 32'h80000000});

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_RNG_LO  = 18'h00002,
    S_RNG_HI  = 18'h00004,
    S_SRCH    = 18'h00008,
    S_SCMP    = 18'h00010,
    S_FETCH   = 18'h00020,
    S_D_SETUP = 18'h00040,
    S_D_MUL   = 18'h00080,
    S_D_DIV   = 18'h00100,
    S_T_SETUP = 18'h00200,
    S_T_DIV   = 18'h00400,
    S_T_SQ    = 18'h00800,
    S_T2_MUL  = 18'h01000,
    S_T3_MUL  = 18'h02000,
    S_H_SETUP = 18'h04000,
    S_H_MUL   = 18'h08000,
    S_FINISH  = 18'h10000,
    S_OUT     = 18'h20000
  } state_t;

  state_t state;

  // Configuration
  logic [NCFG_W-1:0] num_nodes;
  logic [CNT_W-1:0]  n_eff;

  // Table ports
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr;
  logic [IDX_W-1:0] tbl_raddr;
  logic [WORD_W-1:0] node_rd;
  logic [WORD_W-1:0] value_rd;

  // Query registers
  logic signed [WORD_W-1:0] xq, lo, x0, x1, f0, f1, xm, fm, xp, fp;
  logic [CNT_W-1:0] first, size;
  logic [IDX_W-1:0] idx;
  logic [2:0]       fstep;
  logic             dsel;
  logic [1:0]       hk;
  logic signed [DW-1:0] d0, d1;
  logic [TW-1:0]    t, t2, t3;
  logic signed [ACC_W-1:0] acc;

  // Shared multiplier
  logic [PROD_W-1:0] mcand, prod;
  logic [MB_W-1:0]   mplier;
  logic              mneg;

  // Shared divider
  logic [DIVD_W-1:0] dvd, quo;
  logic [31:0]       dvsr, rem;
  logic [DCNT_W-1:0] dcnt;
  logic [32:0]       r2;
  logic              r_ge;

  // Combinational helpers
  logic [CNT_W-1:0]  half, middle;
  logic [CNT_W:0]    idx_p2;
  logic              has_right;
  logic signed [32:0] w, dx, fdiff, tb, tc;
  logic              t_exists, tsa, tsb, tsc;
  logic [31:0]       ua, ub, uc;
  logic              qsat;
  logic [MA_W-1:0]   qm;
  logic signed [DW-1:0] dval;
  logic [TW-1:0]     t2v, t3v;
  logic signed [HW-1:0] ht, ht2, ht3, h00, h01, h10, h11, hsel;
  logic signed [DW-1:0] vsel;
  logic [MA_W-1:0]   vabs;
  logic [HW-1:0]     habs;
  logic signed [ACC_W-1:0] prod_s, shifted;

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 32'(-v) : 32'(v);
  endfunction

  // Tables
  crs_ram #(.WIDTH(WORD_W), .DEPTH(MAX_NODES)) u_node_ram (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(node_word),
    .raddr(tbl_raddr), .rdata(node_rd)
  );

  crs_ram #(.WIDTH(WORD_W), .DEPTH(MAX_NODES)) u_value_ram (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(value_word),
    .raddr(tbl_raddr), .rdata(value_rd)
  );

  // Handshake
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  // Load writes
  assign tbl_we    = in_valid && !in_stall && (cmd == CMD_LOAD) &&
                     (32'(entry_index) < MAX_NODES);
  assign tbl_waddr = IDX_W'(entry_index);

  // Effective node count
  always_comb begin
    if (num_nodes < NCFG_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (32'(num_nodes) > MAX_NODES) begin
      n_eff = CNT_W'(MAX_NODES);
    end else begin
      n_eff = CNT_W'(num_nodes);
    end
  end

  // Search and neighbor helpers
  assign half      = size >> 1;
  assign middle    = first + half;
  assign idx_p2    = (CNT_W+1)'(idx) + (CNT_W+1)'(2);
  assign has_right = idx_p2 < (CNT_W+1)'(n_eff);

  // Table read address
  always_comb begin
    case (state)
      S_RNG_LO: tbl_raddr = IDX_W'(n_eff - CNT_W'(1));
      S_SRCH:   tbl_raddr = IDX_W'(middle);
      S_FETCH: begin
        case (fstep)
          3'd0:    tbl_raddr = idx;
          3'd1:    tbl_raddr = idx + IDX_W'(1);
          3'd2:    tbl_raddr = idx - IDX_W'(1);
          default: tbl_raddr = idx + IDX_W'(2);
        endcase
      end
      default:  tbl_raddr = '0;
    endcase
  end

  // Tangent operands
  assign w     = 33'(x1) - 33'(x0);
  assign dx    = 33'(xq) - 33'(x0);
  assign fdiff = 33'(f1) - 33'(f0);
  always_comb begin
    if (!dsel) begin
      t_exists = (idx != '0);
      tb = 33'(f1) - 33'(fm);
      tc = 33'(x1) - 33'(xm);
    end else begin
      t_exists = has_right;
      tb = 33'(fp) - 33'(f0);
      tc = 33'(xp) - 33'(x0);
    end
  end
  assign tsa = w[32];
  assign tsb = tb[32];
  assign tsc = tc[32];
  assign ua  = mag33(w);
  assign ub  = mag33(tb);
  assign uc  = mag33(tc);

  // Tangent quotient saturation and sign
  assign qsat = |quo[DIVD_W-1:MA_W];
  assign qm   = qsat ? {MA_W{1'b1}} : quo[MA_W-1:0];
  assign dval = mneg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});

  // Divider step
  assign r2   = {rem, dvd[DIVD_W-1]};
  assign r_ge = r2 >= {1'b0, dvsr};

  // Powers of t from the product
  assign t2v = TW'(prod >> F);
  assign t3v = TW'(prod >> F);

  // Hermite basis
  assign ht  = $signed(HW'(t));
  assign ht2 = $signed(HW'(t2));
  assign ht3 = $signed(HW'(t3));
  assign h00 = (ht3 <<< 1) - ((ht2 <<< 1) + ht2) + $signed(HW'(ONE_T));
  assign h01 = ((ht2 <<< 1) + ht2) - (ht3 <<< 1);
  assign h10 = ht3 - (ht2 <<< 1) + ht;
  assign h11 = ht3 - ht2;

  always_comb begin
    case (hk)
      2'd0:    begin hsel = h00; vsel = DW'(f0); end
      2'd1:    begin hsel = h01; vsel = DW'(f1); end
      2'd2:    begin hsel = h10; vsel = d0;      end
      default: begin hsel = h11; vsel = d1;      end
    endcase
  end
  assign vabs = vsel[DW-1] ? MA_W'(-vsel) : MA_W'(vsel);
  assign habs = hsel[HW-1] ? HW'(-hsel) : HW'(hsel);

  // Accumulation and final scaling
  assign prod_s  = $signed(ACC_W'(prod));
  assign shifted = acc >>> F;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_nodes <= NCFG_W'(2);
    end else if (cfg_we) begin
      num_nodes <= cfg_wdata;
    end
  end

  // Sequencer and shared datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && (cmd == CMD_QUERY)) begin
            xq    <= query_x;
            acc   <= '0;
            hk    <= '0;
            state <= S_RNG_LO;
          end
        end

        // Range check against first and last nodes
        S_RNG_LO: begin
          lo    <= $signed(node_rd);
          state <= S_RNG_HI;
        end
        S_RNG_HI: begin
          if (xq < lo || xq > $signed(node_rd)) begin
            result_value <= '0;
            in_range     <= 1'b0;
            state        <= S_OUT;
          end else begin
            first <= CNT_W'(1);
            size  <= n_eff - CNT_W'(2);
            state <= S_SRCH;
          end
        end

        // Binary search, one probe per pass through S_SRCH and S_SCMP
        S_SRCH: begin
          if (size == '0) begin
            idx   <= IDX_W'(first - CNT_W'(1));
            fstep <= '0;
            state <= S_FETCH;
          end else begin
            state <= S_SCMP;
          end
        end
        S_SCMP: begin
          if ($signed(node_rd) <= xq) begin
            first <= middle + CNT_W'(1);
            size  <= size - half - CNT_W'(1);
          end else begin
            size  <= half;
          end
          state <= S_SRCH;
        end

        // Fetch interval and neighbor entries
        S_FETCH: begin
          fstep <= fstep + 3'd1;
          case (fstep)
            3'd1: begin x0 <= $signed(node_rd); f0 <= $signed(value_rd); end
            3'd2: begin x1 <= $signed(node_rd); f1 <= $signed(value_rd); end
            3'd3: begin xm <= $signed(node_rd); fm <= $signed(value_rd); end
            3'd4: begin
              xp    <= $signed(node_rd);
              fp    <= $signed(value_rd);
              dsel  <= 1'b0;
              state <= S_D_SETUP;
            end
            default: ;
          endcase
        end

        // Tangents
        S_D_SETUP: begin
          if (!t_exists || uc == '0) begin
            if (!dsel) d0 <= t_exists ? '0 : DW'(fdiff);
            else       d1 <= t_exists ? '0 : DW'(fdiff);
            dsel  <= 1'b1;
            state <= dsel ? S_T_SETUP : S_D_SETUP;
          end else begin
            mcand  <= PROD_W'(ua);
            mplier <= MB_W'(ub);
            prod   <= '0;
            dvsr   <= uc;
            mneg   <= tsa ^ tsb ^ tsc;
            state  <= S_D_MUL;
          end
        end
        S_D_MUL: begin
          if (mplier != '0) begin
            if (mplier[0]) prod <= prod + mcand;
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
          end else begin
            dvd   <= prod[DIVD_W-1:0];
            rem   <= '0;
            quo   <= '0;
            dcnt  <= DCNT_W'(DIVD_W);
            state <= S_D_DIV;
          end
        end
        S_D_DIV: begin
          if (dcnt != '0) begin
            rem  <= r_ge ? 32'(r2 - {1'b0, dvsr}) : r2[31:0];
            quo  <= {quo[DIVD_W-2:0], r_ge};
            dvd  <= dvd << 1;
            dcnt <= dcnt - DCNT_W'(1);
          end else begin
            if (!dsel) d0 <= dval;
            else       d1 <= dval;
            dsel  <= 1'b1;
            state <= dsel ? S_T_SETUP : S_D_SETUP;
          end
        end

        // Local parameter t
        S_T_SETUP: begin
          if (dx <= 0 || w <= 0) begin
            t     <= '0;
            state <= S_T_SQ;
          end else if (dx >= w) begin
            t     <= ONE_T;
            state <= S_T_SQ;
          end else begin
            dvd   <= DIVD_W'(dx[31:0]) << F;
            dvsr  <= w[31:0];
            rem   <= '0;
            quo   <= '0;
            dcnt  <= DCNT_W'(DIVD_W);
            state <= S_T_DIV;
          end
        end
        S_T_DIV: begin
          if (dcnt != '0) begin
            rem  <= r_ge ? 32'(r2 - {1'b0, dvsr}) : r2[31:0];
            quo  <= {quo[DIVD_W-2:0], r_ge};
            dvd  <= dvd << 1;
            dcnt <= dcnt - DCNT_W'(1);
          end else begin
            t     <= quo[TW-1:0];
            state <= S_T_SQ;
          end
        end
        S_T_SQ: begin
          mcand  <= PROD_W'(t);
          mplier <= MB_W'(t);
          prod   <= '0;
          state  <= S_T2_MUL;
        end
        S_T2_MUL: begin
          if (mplier != '0) begin
            if (mplier[0]) prod <= prod + mcand;
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
          end else begin
            t2     <= t2v;
            mcand  <= PROD_W'(t2v);
            mplier <= MB_W'(t);
            prod   <= '0;
            state  <= S_T3_MUL;
          end
        end
        S_T3_MUL: begin
          if (mplier != '0) begin
            if (mplier[0]) prod <= prod + mcand;
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
          end else begin
            t3    <= t3v;
            state <= S_H_SETUP;
          end
        end

        // Hermite sum, one term per multiply
        S_H_SETUP: begin
          mcand  <= PROD_W'(vabs);
          mplier <= MB_W'(habs);
          prod   <= '0;
          mneg   <= vsel[DW-1] ^ hsel[HW-1];
          state  <= S_H_MUL;
        end
        S_H_MUL: begin
          if (mplier != '0) begin
            if (mplier[0]) prod <= prod + mcand;
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
          end else begin
            acc   <= mneg ? acc - prod_s : acc + prod_s;
            hk    <= hk + 2'd1;
            state <= (hk == 2'd3) ? S_FINISH : S_H_SETUP;
          end
        end

        // Floor scaling and saturation
        S_FINISH: begin
          if (shifted > RES_MAX) begin
            result_value <= 32'sh7fffffff;
          end else if (shifted < RES_MIN) begin
            result_value <= $signed(32'h80000000);
          end else begin
            result_value <= shifted[31:0];
          end
          in_range <= 1'b1;
          state    <= S_OUT;
        end

        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/crs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module crs_ram
  import crs_pkg::*;
#(
  parameter int WIDTH = WORD_W,
  parameter int DEPTH = MAX_NODES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- tb/catmull_rom_spline_eval_test.sv -----
// Self-checking testbench for the Catmull-Rom spline evaluator.
`default_nettype none
module catmull_rom_spline_eval_test;
  import crs_pkg::*;

  localparam int NODES = MAX_NODES_DEF;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint TAN_MAX = 64'h1F_FFFF_FFFF;
  localparam int IDLE_WAIT = 600;      // longest query plus margin

  typedef struct packed {
    logic [31:0] value;
    logic        hit;
  } spline_result_t;

  typedef struct {
    logic        cmd;
    logic [5:0]  entry;
    logic [31:0] node;
    logic [31:0] value;
    logic [31:0] x;
    bit          typed;
    logic [31:0] want_value;
    logic        want_hit;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = CMD_LOAD;
  logic [ENTRY_W-1:0] entry_index = '0;
  logic signed [WORD_W-1:0] node_word = '0;
  logic signed [WORD_W-1:0] value_word = '0;
  logic signed [WORD_W-1:0] query_x = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [WORD_W-1:0] result_value;
  logic in_range;
  logic cfg_we = 1'b0;
  logic [NCFG_W-1:0] cfg_wdata = '0;

  // Predictor state
  logic [31:0] node_mem [NODES];
  logic [31:0] value_mem [NODES];
  logic [6:0] node_count;

  spline_result_t pending_results[$];
  int errors = 0;
  int checked = 0;
  int loads_sent = 0;
  int queries_sent = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  bit hold_request = 0;

  catmull_rom_spline_eval DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .entry_index(entry_index),
    .node_word(node_word), .value_word(value_word), .query_x(query_x),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .in_range(in_range),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Tangent: a*b/c truncated toward zero, saturated; 0 for a zero divisor
  function automatic longint tangent(longint a, longint b, longint c);
    logic [127:0] ua, ub, uc, quot;
    longint q;
    bit neg;
    ua = 128'(a < 0 ? -a : a);
    ub = 128'(b < 0 ? -b : b);
    uc = 128'(c < 0 ? -c : c);
    if (uc == 0) return 0;
    quot = (ua * ub) / uc;
    q = quot > TAN_MAX ? TAN_MAX : longint'(quot[63:0]);
    neg = ((a < 0) != (b < 0)) && q != 0;
    if (c < 0) neg = !neg && q != 0;
    return neg ? -q : q;
  endfunction

  function automatic int active_nodes();
    if (node_count < 2) return 2;
    if (node_count > NODES) return NODES;
    return node_count;
  endfunction

  function automatic longint sx(logic [31:0] w);
    return longint'(signed'(w));
  endfunction

  // Spline evaluation at x over the current table
  function automatic spline_result_t eval_spline(logic [31:0] xw);
    spline_result_t r;
    int n, first, size, half, mid, idx;
    longint x, x0, x1, f0, f1, width, d0, d1, dx, t, t2, t3, sum, res;
    n = active_nodes();
    x = sx(xw);
    r.value = '0;
    r.hit = 1'b0;
    if (x < sx(node_mem[0]) || x > sx(node_mem[n-1])) return r;
    size = n - 2;
    first = 1;
    while (size > 0) begin
      half = size >> 1;
      mid = first + half;
      if (sx(node_mem[mid]) <= x) begin
        first = mid + 1;
        size -= half + 1;
      end else begin
        size = half;
      end
    end
    idx = first - 1;
    if (idx > n - 2) idx = n - 2;
    x0 = sx(node_mem[idx]);
    x1 = sx(node_mem[idx+1]);
    f0 = sx(value_mem[idx]);
    f1 = sx(value_mem[idx+1]);
    width = x1 - x0;
    if (idx > 0)
      d0 = tangent(width, f1 - sx(value_mem[idx-1]), x1 - sx(node_mem[idx-1]));
    else
      d0 = f1 - f0;
    if (idx + 2 < n)
      d1 = tangent(width, sx(value_mem[idx+2]) - f0, sx(node_mem[idx+2]) - x0);
    else
      d1 = f1 - f0;
    dx = x - x0;
    if (dx <= 0 || width <= 0) t = 0;
    else if (dx >= width) t = 64'd1 << FRAC;
    else t = (dx << FRAC) / width;
    t2 = (t * t) >> FRAC;
    t3 = (t2 * t) >> FRAC;
    sum = (2*t3 - 3*t2 + (64'sd1 << FRAC)) * f0 + (3*t2 - 2*t3) * f1
        + (t3 - 2*t2 + t) * d0 + (t3 - t2) * d1;
    res = sum >>> FRAC;
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    r.value = res[31:0];
    r.hit = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h (result %0d)", what, got, want, checked);
    errors++;
  endtask

  // Hand one request to the block; updates the predictor when accepted
  task automatic send_request(logic c, logic [5:0] e, logic [31:0] nw, logic [31:0] vw,
                              logic [31:0] xw, bit typed = 0,
                              logic [31:0] want_v = '0, logic want_h = 0);
    spline_result_t r;
    int gap;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    entry_index <= e;
    node_word <= nw;
    value_word <= vw;
    query_x <= xw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (c == CMD_LOAD) begin
      node_mem[e] = nw;
      value_mem[e] = vw;
      loads_sent++;
    end else begin
      r = eval_spline(xw);
      if (typed && (r.value !== want_v || r.hit !== want_h))
        report_mismatch("typed expectation vs predictor", r.value, want_v);
      pending_results.push_back(r);
      queries_sent++;
    end
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_node_count(logic [6:0] v);
    go_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    node_count = v;
  endtask

  // Fill all table entries; mode picks sorted wide, sorted with ties,
  // unsorted, or sorted small steps
  task automatic fill_table(int mode);
    logic [31:0] nodes[$];
    longint acc;
    for (int i = 0; i < NODES; i++) begin
      case (mode)
        0: nodes.push_back($urandom);
        1: nodes.push_back($urandom_range(0, 40) - 20);
        2: nodes.push_back($urandom);
        default: nodes.push_back($urandom_range(1, 1 << 20));
      endcase
    end
    if (mode == 3) begin
      acc = -longint'($urandom_range(0, 1 << 30));
      for (int i = 0; i < NODES; i++) begin
        acc += sx(nodes[i]);
        nodes[i] = acc[31:0];
      end
    end else if (mode != 2) begin
      nodes.sort() with (sx(item));
    end
    for (int i = 0; i < NODES; i++)
      send_request(CMD_LOAD, i[5:0], nodes[i],
                   ($urandom_range(0, 3) == 0) ? $urandom : ($urandom_range(0, 1 << 22) - (1 << 21)),
                   $urandom);
  endtask

  // Mostly in-range points, plus exact nodes, random points and reloads
  task automatic random_queries(int count);
    int n, k, pick;
    longint lo, hi, x;
    n = active_nodes();
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, n - 2);
      lo = sx(node_mem[k]);
      hi = sx(node_mem[k+1]);
      if (pick < 70) x = lo + (((hi - lo) * longint'($urandom_range(0, 65535))) >>> 16);
      else if (pick < 80) x = ($urandom_range(0, 1)) ? hi : lo;
      else x = sx($urandom);
      if (pick >= 95)
        send_request(CMD_LOAD, 6'($urandom_range(0, NODES - 1)), node_mem[k] , $urandom,
                     $urandom);
      else
        send_request(CMD_QUERY, 6'($urandom), $urandom, $urandom, x[31:0]);
    end
  endtask

  // Receiver: random stall, or a long hold-off on request
  initial begin
    int held;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        for (held = 0; held < 1500; held++) @(posedge clk);
        hold_request = 0;
      end
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    spline_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", result_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (result_value !== want.value) report_mismatch("result_value", result_value, want.value);
        if (in_range !== want.hit) report_mismatch("in_range", 32'(in_range), 32'(want.hit));
      end
      checked++;
    end
  end

  // Directed table: typed results where they are obvious
  stim_row_t directed[] = '{
    '{CMD_LOAD,  0, 32'h0000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0},
    '{CMD_LOAD,  1, 32'h0001_0000, 32'h8000_0000, 0, 0, 0, 0},
    '{CMD_QUERY, 0, 0, 0, 32'hFFFF_FFFF, 1, 32'h0, 1'b0},
    '{CMD_QUERY, 0, 0, 0, 32'h0000_0000, 1, 32'h7FFF_FFFF, 1'b1},
    '{CMD_QUERY, 0, 0, 0, 32'h0001_0000, 1, 32'h8000_0000, 1'b1},
    '{CMD_QUERY, 63, 0, 0, 32'h0000_8000, 0, 0, 0},
    '{CMD_QUERY, 0, 0, 0, 32'h0001_0001, 1, 32'h0, 1'b0},
    '{CMD_LOAD,  0, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0},
    '{CMD_LOAD,  1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0},
    '{CMD_QUERY, 0, 0, 0, 32'h8000_0000, 1, 32'h8000_0000, 1'b1},
    '{CMD_QUERY, 0, 0, 0, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1'b1},
    '{CMD_QUERY, 0, 0, 0, 32'h0000_0000, 0, 0, 0},
    '{CMD_QUERY, 0, 0, 0, 32'h1234_5678, 0, 0, 0},
    // zero-width interval: t stays 0, value of the left node
    '{CMD_LOAD,  1, 32'h8000_0000, 32'h0000_1234, 0, 0, 0, 0},
    '{CMD_QUERY, 0, 0, 0, 32'h8000_0000, 1, 32'h8000_0000, 1'b1},
    '{CMD_QUERY, 0, 0, 0, 32'h8000_0001, 1, 32'h0, 1'b0},
    '{CMD_LOAD,  63, 32'hFFFF_FFFF, 32'hAAAA_5555, 0, 0, 0, 0},
    '{CMD_LOAD,  1, 32'h0003_0000, 32'h0002_0000, 0, 0, 0, 0},
    '{CMD_LOAD,  0, 32'hFFFE_0000, 32'hFFFF_0000, 0, 0, 0, 0},
    '{CMD_QUERY, 0, 0, 0, 32'h0000_0000, 0, 0, 0},
    '{CMD_QUERY, 0, 0, 0, 32'hFFFF_8000, 0, 0, 0}
  };

  initial begin
    logic [6:0] counts[8] = '{7'd64, 7'd0, 7'd127, 7'd3, 7'd1, 7'd2, 7'd17, 7'd64};
    int modes[8] = '{0, 3, 1, 0, 3, 2, 3, 0};
    for (int i = 0; i < NODES; i++) begin
      node_mem[i] = '0;
      value_mem[i] = '0;
    end
    node_count = 7'd2;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_request(directed[i].cmd, directed[i].entry, directed[i].node, directed[i].value,
                   directed[i].x, directed[i].typed, directed[i].want_value,
                   directed[i].want_hit);

    // Random phases: each sets the node count and rebuilds the table
    for (int p = 0; p < 8; p++) begin
      if (p < 3) begin
        sender_idle_pct = 35;
        receiver_idle_pct = 85;
      end else if (p < 6) begin
        sender_idle_pct = 85;
        receiver_idle_pct = 35;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      write_node_count(p == 6 ? 7'($urandom_range(4, 63)) : counts[p]);
      fill_table(modes[p]);
      if (p == 1) hold_request = 1;
      random_queries(p == 5 ? 60 : 105);
    end

    go_idle();
    $display("Covered %0d loads and %0d queries, %0d results compared,", loads_sent,
             queries_sent, checked);
    $display("node counts from below the minimum to above the table size.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #40000000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
sv/crs_pkg.sv
sv/crs_ram.sv
sv/catmull_rom_spline_eval.sv
tb/catmull_rom_spline_eval_test.sv
